@@ hw/rtl/sabc_pkg.sv @@
// shared types and constants for the block buffer cache controller
`timescale 1ns / 1ps
package sabc_pkg;
   localparam int GROUPS = 16;
   localparam int WAYS = 8;
   localparam int NSLOTS = GROUPS * WAYS;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int GRP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SLOT_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
   localparam int CNT_W = WAY_W + 1;

   localparam logic [1:0] ACT_ACQUIRE = 2'd0;
   localparam logic [1:0] ACT_DIRTY = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   localparam logic [2:0] ST_HIT = 3'd0;
   localparam logic [2:0] ST_MISS = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;
   localparam logic [2:0] ST_UNREF = 3'd4;

   // one tag and state entry; rank is held separately
   typedef struct packed {
      logic [7:0] dev;
      logic [31:0] blk;
      logic used;
      logic valid;
      logic dirty;
      logic [7:0] refs;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] dev;
      logic [31:0] block_number;
      logic [6:0] slot;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] slot_res;
      logic writeback;
      logic [7:0] writeback_dev;
      logic [31:0] writeback_block;
      logic fill;
   } rsp_type;
endpackage

@@ hw/rtl/sabc_req_if.sv @@
// valid/ready channel carrying one cache request
`timescale 1ns / 1ps
interface sabc_req_if;
   logic valid;
   logic ready;
   sabc_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/sabc_rsp_if.sv @@
// valid/ready channel carrying one cache response
`timescale 1ns / 1ps
interface sabc_rsp_if;
   logic valid;
   logic ready;
   sabc_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/sabc_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
module sabc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] addr,
   input logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

@@ hw/rtl/set_assoc_block_buffer_cache_core.sv @@
// top level: cache controller sequencing way scans over tag and rank memories
// acquire runs a hit scan; a miss or no buffer free also runs a victim scan after it
//   (each way is read, then compared)
// mark-dirty and release read the slot; release to count zero adds a rank update scan
// one request at a time; input is ready again the cycle after the response is taken
// reset: synchronous, active high; clearing pass over all NSLOTS slots, no requests taken
`timescale 1ns / 1ps
module set_assoc_block_buffer_cache_core (
   input logic clock,
   input logic reset,
   sabc_req_if.sink req,
   sabc_rsp_if.source rsp
);
   import sabc_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_HRD = 4'd2;
   localparam logic [3:0] S_HCHK = 4'd3;
   localparam logic [3:0] S_VRD = 4'd4;
   localparam logic [3:0] S_VCHK = 4'd5;
   localparam logic [3:0] S_WRITE = 4'd6;
   localparam logic [3:0] S_SRD = 4'd7;
   localparam logic [3:0] S_SCHK = 4'd8;
   localparam logic [3:0] S_RRD = 4'd9;
   localparam logic [3:0] S_RCHK = 4'd10;
   localparam logic [3:0] S_OUT = 4'd11;

   logic [3:0] state_ff, state_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W:0] clr_ff, clr_in;
   logic [CNT_W-1:0] way_ff, way_in;
   logic found_ff, found_in;
   logic [WAY_W-1:0] best_ff, best_in;
   logic [WAY_W-1:0] best_rank_ff, best_rank_in;
   logic [WAY_W-1:0] old_rank_ff, old_rank_in;
   entry_type ent_ff, ent_in;

   // ram ports
   logic e_we, r_we;
   logic [SLOT_W-1:0] addr;
   entry_type e_wd, e_rd;
   logic [WAY_W-1:0] r_wd, r_rd;

   sabc_ram #(.WIDTH(ENTRY_W), .DEPTH(NSLOTS)) u_ent (
      .clock(clock), .wr_en(e_we), .addr(addr), .wr_data(e_wd), .rd_data(e_rd));
   sabc_ram #(.WIDTH(WAY_W), .DEPTH(NSLOTS)) u_rank (
      .clock(clock), .wr_en(r_we), .addr(addr), .wr_data(r_wd), .rd_data(r_rd));

   logic [GRP_W-1:0] grp;
   logic [WAY_W-1:0] way_i;
   logic [SLOT_W-1:0] base, slot_a;
   logic slot_ok;
   logic hit;

   assign grp = (GROUPS > 1) ? req_ff.block_number[GRP_W-1:0] : '0;
   assign way_i = way_ff[WAY_W-1:0];
   assign base = SLOT_W'(grp) * SLOT_W'(WAYS);
   assign slot_a = req_ff.slot[SLOT_W-1:0];
   assign slot_ok = {1'b0, req_ff.slot} < 8'(NSLOTS);
   assign hit = e_rd.used && e_rd.dev == req_ff.dev && e_rd.blk == req_ff.block_number;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      clr_in = clr_ff;
      way_in = way_ff;
      found_in = found_ff;
      best_in = best_ff;
      best_rank_in = best_rank_ff;
      old_rank_in = old_rank_ff;
      ent_in = ent_ff;
      e_we = 1'b0;
      r_we = 1'b0;
      addr = '0;
      e_wd = '0;
      r_wd = '0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            addr = clr_ff[SLOT_W-1:0];
            e_we = 1'b1;
            r_we = 1'b1;
            r_wd = clr_ff[WAY_W-1:0];
            if (WAYS == 1) r_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SLOT_W+1)'(NSLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid && !rsp_valid_ff) begin
               req_in = req.payload;
               way_in = '0;
               found_in = 1'b0;
               unique case (req.payload.action)
                  ACT_ACQUIRE: state_in = S_HRD;
                  ACT_DIRTY: state_in = S_SRD;
                  ACT_RELEASE: state_in = S_SRD;
                  default: begin
                     rsp_in = '0;
                     rsp_in.status = ST_DONE;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         // hit scan: read one way, then compare
         S_HRD: begin
            addr = base + SLOT_W'(way_i);
            state_in = S_HCHK;
         end
         S_HCHK: begin
            addr = base + SLOT_W'(way_i);
            if (hit) begin
               ent_in = e_rd;
               best_in = way_i;
               rsp_in = '0;
               rsp_in.status = ST_HIT;
               rsp_in.slot_res = 7'(base + SLOT_W'(way_i));
               rsp_in.fill = !e_rd.valid;
               state_in = S_WRITE;
            end else if (way_ff == CNT_W'(WAYS - 1)) begin
               way_in = '0;
               state_in = S_VRD;
            end else begin
               way_in = way_ff + 1'b1;
               state_in = S_HRD;
            end
         end
         // victim scan: oldest way with zero count
         S_VRD: begin
            addr = base + SLOT_W'(way_i);
            state_in = S_VCHK;
         end
         S_VCHK: begin
            addr = base + SLOT_W'(way_i);
            if (e_rd.refs == 8'd0 && (!found_ff || r_rd > best_rank_ff)) begin
               found_in = 1'b1;
               best_in = way_i;
               best_rank_in = r_rd;
               ent_in = e_rd;
            end
            if (way_ff == CNT_W'(WAYS - 1)) begin
               rsp_in = '0;
               if (!(found_ff || e_rd.refs == 8'd0)) begin
                  rsp_in.status = ST_FULL;
                  state_in = S_OUT;
               end else begin
                  state_in = S_WRITE;
               end
            end else begin
               way_in = way_ff + 1'b1;
               state_in = S_VRD;
            end
         end
         // write the chosen entry back
         S_WRITE: begin
            addr = base + SLOT_W'(best_ff);
            e_we = 1'b1;
            if (rsp_ff.status == ST_HIT && req_ff.action == ACT_ACQUIRE && ent_ff.used
                && ent_ff.dev == req_ff.dev && ent_ff.blk == req_ff.block_number
                && !found_ff) begin
               e_wd = ent_ff;
               if (ent_ff.refs != 8'hFF) e_wd.refs = ent_ff.refs + 1'b1;
               e_wd.valid = 1'b1;
            end else begin
               e_wd.dev = req_ff.dev;
               e_wd.blk = req_ff.block_number;
               e_wd.used = 1'b1;
               e_wd.valid = 1'b1;
               e_wd.dirty = 1'b0;
               e_wd.refs = 8'd1;
               rsp_in.status = ST_MISS;
               rsp_in.slot_res = 7'(base + SLOT_W'(best_ff));
               rsp_in.fill = 1'b1;
               if (ent_ff.valid && ent_ff.dirty) begin
                  rsp_in.writeback = 1'b1;
                  rsp_in.writeback_dev = ent_ff.dev;
                  rsp_in.writeback_block = ent_ff.blk;
               end
            end
            state_in = S_OUT;
         end
         // slot read for mark-dirty and release
         S_SRD: begin
            addr = slot_a;
            rsp_in = '0;
            rsp_in.slot_res = req_ff.slot;
            if (!slot_ok) begin
               rsp_in.status = (req_ff.action == ACT_DIRTY) ? ST_DONE : ST_UNREF;
               state_in = S_OUT;
            end else begin
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            addr = slot_a;
            e_wd = e_rd;
            old_rank_in = r_rd;
            rsp_in.status = ST_DONE;
            state_in = S_OUT;
            if (req_ff.action == ACT_DIRTY) begin
               e_wd.dirty = 1'b1;
               e_we = 1'b1;
            end else if (e_rd.refs == 8'd0) begin
               rsp_in.status = ST_UNREF;
            end else begin
               e_wd.refs = e_rd.refs - 1'b1;
               e_we = 1'b1;
               if (e_rd.refs == 8'd1) begin
                  way_in = '0;
                  state_in = S_RRD;
               end
            end
         end
         // rank update scan: age younger ways, target becomes rank zero
         S_RRD: begin
            addr = SLOT_W'(slot_a / SLOT_W'(WAYS) * SLOT_W'(WAYS)) + SLOT_W'(way_i);
            state_in = S_RCHK;
         end
         S_RCHK: begin
            addr = SLOT_W'(slot_a / SLOT_W'(WAYS) * SLOT_W'(WAYS)) + SLOT_W'(way_i);
            r_we = 1'b1;
            if (addr == slot_a) r_wd = '0;
            else if (r_rd < old_rank_ff) r_wd = r_rd + 1'b1;
            else r_wd = r_rd;
            if (way_ff == CNT_W'(WAYS - 1)) begin
               state_in = S_OUT;
            end else begin
               way_in = way_ff + 1'b1;
               state_in = S_RRD;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff <= clr_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      way_ff <= way_in;
      found_ff <= found_in;
      best_ff <= best_in;
      best_rank_ff <= best_rank_in;
      old_rank_ff <= old_rank_in;
      ent_ff <= ent_in;
   end
endmodule

@@ hw/rtl/sabc_checker.sv @@
// port-level checks for the cache controller, bound to the top level
`timescale 1ns / 1ps
module sabc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input sabc_pkg::rsp_type rsp_payload
);
   import sabc_pkg::*;

   // no request is taken back to back
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken back to back");

   // held response stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped");

   // write-back only comes with a miss fill
   a_wb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.writeback) |-> rsp_payload.status == ST_MISS
         && rsp_payload.fill)
      else $error("write-back without miss");

   // full reports carry no slot and no fill
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_FULL) |-> rsp_payload.slot_res == 7'd0
         && !rsp_payload.fill)
      else $error("bad no-buffer report");
endmodule

bind set_assoc_block_buffer_cache_core sabc_checker u_sabc_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload));

@@ tb/tb_set_assoc_block_buffer_cache_core.sv @@
// testbench for the block buffer cache controller: directed table plus random requests
`timescale 1ns / 1ps
module tb_set_assoc_block_buffer_cache_core;
   import sabc_pkg::*;

   localparam logic [1:0] ACT_UNKNOWN = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 4 * WAYS + 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sabc_req_if req_if ();
   sabc_rsp_if rsp_if ();

   set_assoc_block_buffer_cache_core uut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   // clock generation
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow cache state
   logic [7:0] shadow_dev [NSLOTS];
   logic [31:0] shadow_blk [NSLOTS];
   logic shadow_used [NSLOTS];
   logic shadow_valid [NSLOTS];
   logic shadow_dirty [NSLOTS];
   logic [7:0] shadow_refs [NSLOTS];
   logic [2:0] shadow_rank [NSLOTS];

   rsp_type pending_rsps [$];
   int errors = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   bit rx_hold = 1'b0;

   // directed table; check_row set where the response is known outright
   typedef struct {
      req_type r;
      bit check_row;
      rsp_type e;
   } dir_row_type;
   dir_row_type dir_tab [$];

   function automatic rsp_type mk_rsp(logic [2:0] st, logic [6:0] s, logic wb,
                                      logic [7:0] wd, logic [31:0] wbk, logic fl);
      rsp_type o;
      o.status = st; o.slot_res = s; o.writeback = wb;
      o.writeback_dev = wd; o.writeback_block = wbk; o.fill = fl;
      return o;
   endfunction

   task automatic cache_reset_shadow();
      for (int i = 0; i < NSLOTS; i++) begin
         shadow_dev[i] = '0; shadow_blk[i] = '0; shadow_used[i] = 1'b0;
         shadow_valid[i] = 1'b0; shadow_dirty[i] = 1'b0; shadow_refs[i] = '0;
         shadow_rank[i] = 3'(i % WAYS);
      end
   endtask

   // predict one response and update the shadow state
   function automatic rsp_type cache_predict(req_type r);
      rsp_type o;
      int base, best, s;
      logic [2:0] old;
      o = mk_rsp(ST_DONE, '0, 1'b0, '0, '0, 1'b0);
      case (r.action)
         ACT_ACQUIRE: begin
            base = (r.block_number % GROUPS) * WAYS;
            for (int w = 0; w < WAYS; w++) begin
               s = base + w;
               if (shadow_used[s] && shadow_dev[s] == r.dev
                   && shadow_blk[s] == r.block_number) begin
                  o = mk_rsp(ST_HIT, 7'(s), 1'b0, '0, '0, !shadow_valid[s]);
                  if (shadow_refs[s] != 8'd255) shadow_refs[s]++;
                  shadow_valid[s] = 1'b1;
                  return o;
               end
            end
            best = -1;
            for (int w = 0; w < WAYS; w++) begin
               s = base + w;
               if (shadow_refs[s] == 0 && (best < 0 || shadow_rank[s] > shadow_rank[best]))
                  best = s;
            end
            if (best < 0) return mk_rsp(ST_FULL, '0, 1'b0, '0, '0, 1'b0);
            if (shadow_valid[best] && shadow_dirty[best])
               o = mk_rsp(ST_MISS, 7'(best), 1'b1, shadow_dev[best], shadow_blk[best], 1'b1);
            else
               o = mk_rsp(ST_MISS, 7'(best), 1'b0, '0, '0, 1'b1);
            shadow_dev[best] = r.dev; shadow_blk[best] = r.block_number;
            shadow_used[best] = 1'b1; shadow_dirty[best] = 1'b0;
            shadow_refs[best] = 8'd1; shadow_valid[best] = 1'b1;
         end
         ACT_DIRTY: begin
            if (r.slot < NSLOTS) shadow_dirty[r.slot] = 1'b1;
            o = mk_rsp(ST_DONE, r.slot, 1'b0, '0, '0, 1'b0);
         end
         ACT_RELEASE: begin
            if (r.slot >= NSLOTS || shadow_refs[r.slot] == 0)
               return mk_rsp(ST_UNREF, r.slot, 1'b0, '0, '0, 1'b0);
            shadow_refs[r.slot]--;
            if (shadow_refs[r.slot] == 0) begin
               // move slot to most recent within its group
               base = (r.slot / WAYS) * WAYS;
               old = shadow_rank[r.slot];
               for (int w = 0; w < WAYS; w++)
                  if (shadow_rank[base + w] < old) shadow_rank[base + w]++;
               shadow_rank[r.slot] = '0;
            end
            o = mk_rsp(ST_DONE, r.slot, 1'b0, '0, '0, 1'b0);
         end
         default: o = mk_rsp(ST_DONE, '0, 1'b0, '0, '0, 1'b0);
      endcase
      return o;
   endfunction

   function automatic req_type mk_req(logic [1:0] a, logic [7:0] d, logic [31:0] b,
                                      logic [6:0] s);
      req_type r;
      r.action = a; r.dev = d; r.block_number = b; r.slot = s;
      return r;
   endfunction

   function automatic void add_row(req_type r, bit chk, rsp_type e);
      dir_row_type d;
      d.r = r; d.check_row = chk; d.e = e;
      dir_tab.push_back(d);
   endfunction

   // random request, mostly well formed with a small working set
   function automatic req_type rand_req();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45)
         return mk_req(ACT_ACQUIRE, 8'($urandom_range(0, 3)),
                       32'($urandom_range(0, 3)) * 32'd16 + 32'($urandom_range(0, 2)),
                       7'($urandom));
      if (k < 55)
         return mk_req(ACT_ACQUIRE, 8'($urandom), $urandom, 7'($urandom));
      if (k < 70)
         return mk_req(ACT_DIRTY, 8'($urandom), $urandom, 7'($urandom_range(0, 23)));
      if (k < 95)
         return mk_req(ACT_RELEASE, 8'($urandom), $urandom, 7'($urandom_range(0, 23)));
      return mk_req(2'($urandom), 8'($urandom), $urandom, 7'($urandom));
   endfunction

   // send one request, checking the directed expectation when given
   task automatic send_req(req_type r, bit chk, rsp_type e);
      rsp_type p;
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      p = cache_predict(r);
      if (chk && p !== e) begin
         $display("%0t table row disagrees with prediction: expected %h actual %h",
                  $time, e, p);
         errors++;
      end
      pending_rsps.push_back(p);
   endtask

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else if (rx_hold) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(0, 3) != 0);
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t unexpected response: expected none actual %h", $time,
                     rsp_if.payload);
            errors++;
         end else begin
            rsp_type e;
            e = pending_rsps.pop_front();
            if (rsp_if.payload.status !== e.status)
               $display("%0t status: expected %0d actual %0d", $time, e.status,
                        rsp_if.payload.status);
            if (rsp_if.payload.slot_res !== e.slot_res)
               $display("%0t slot_res: expected %0d actual %0d", $time, e.slot_res,
                        rsp_if.payload.slot_res);
            if (rsp_if.payload.writeback !== e.writeback)
               $display("%0t writeback: expected %0d actual %0d", $time, e.writeback,
                        rsp_if.payload.writeback);
            if (rsp_if.payload.writeback_dev !== e.writeback_dev)
               $display("%0t writeback_dev: expected %h actual %h", $time,
                        e.writeback_dev, rsp_if.payload.writeback_dev);
            if (rsp_if.payload.writeback_block !== e.writeback_block)
               $display("%0t writeback_block: expected %h actual %h", $time,
                        e.writeback_block, rsp_if.payload.writeback_block);
            if (rsp_if.payload.fill !== e.fill)
               $display("%0t fill: expected %0d actual %0d", $time, e.fill,
                        rsp_if.payload.fill);
            if (rsp_if.payload !== e) errors++;
         end
      end
   end

   // watchdog on cycles without any accepted request or response
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   initial begin
      wait (stim_done == 1'b0 && !reset);
      repeat (3000) @(posedge clock);
      rx_hold = 1'b1;
      repeat (300) @(posedge clock);
      rx_hold = 1'b0;
   end

   // stimulus
   initial begin
      rsp_type z;
      int burst, n;
      z = mk_rsp(ST_DONE, '0, 1'b0, '0, '0, 1'b0);
      req_if.valid = 1'b0;
      req_if.payload = '0;
      cache_reset_shadow();
      // after reset: miss in least recent way 7 of group 0
      add_row(mk_req(ACT_ACQUIRE, 8'd0, 32'd0, 7'd0), 1, mk_rsp(ST_MISS, 7'd7, 0, 0, 0, 1));
      add_row(mk_req(ACT_ACQUIRE, 8'd0, 32'd0, 7'd0), 1, mk_rsp(ST_HIT, 7'd7, 0, 0, 0, 0));
      add_row(mk_req(ACT_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 7'h7F), 1,
              mk_rsp(ST_MISS, 7'd127, 0, 0, 0, 1));
      add_row(mk_req(ACT_DIRTY, 8'd0, 32'd0, 7'd127), 1, mk_rsp(ST_DONE, 7'd127, 0, 0, 0, 0));
      add_row(mk_req(ACT_RELEASE, 8'd0, 32'd0, 7'd127), 1, mk_rsp(ST_DONE, 7'd127, 0, 0, 0, 0));
      add_row(mk_req(ACT_RELEASE, 8'd0, 32'd0, 7'd127), 1, mk_rsp(ST_UNREF, 7'd127, 0, 0, 0, 0));
      add_row(mk_req(ACT_RELEASE, 8'd0, 32'd0, 7'd3), 1, mk_rsp(ST_UNREF, 7'd3, 0, 0, 0, 0));
      add_row(mk_req(ACT_DIRTY, 8'd0, 32'd0, 7'd5), 1, mk_rsp(ST_DONE, 7'd5, 0, 0, 0, 0));
      add_row(mk_req(ACT_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 7'h7F), 1, z);
      // dirty eviction: refill group 15 so slot 127 is reused with a write-back
      for (int i = 1; i < 9; i++)
         add_row(mk_req(ACT_ACQUIRE, 8'h5A, 32'd15 + 32'd16 * i, 7'd0), 0, z);
      // group 15 now fully referenced: no buffer free
      add_row(mk_req(ACT_ACQUIRE, 8'hA5, 32'd15, 7'd0), 1, mk_rsp(ST_FULL, 0, 0, 0, 0, 0));
      add_row(mk_req(ACT_RELEASE, 8'd0, 32'd0, 7'd7), 0, z);
      add_row(mk_req(ACT_RELEASE, 8'd0, 32'd0, 7'd7), 0, z);
      // start driving once reset is released
      @(posedge clock iff !reset);
      for (int i = 0; i < dir_tab.size(); i++)
         send_req(dir_tab[i].r, dir_tab[i].check_row, dir_tab[i].e);
      req_if.valid <= 1'b0;
      // sender pauses until every response has come
      while (pending_rsps.size() != 0) @(posedge clock);
      // saturate a reference count
      for (int i = 0; i < 260; i++)
         send_req(mk_req(ACT_ACQUIRE, 8'd9, 32'd1, 7'd0), 0, z);
      // random part in bursts
      n = 0;
      while (n < 120) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst; b++) begin
            send_req(rand_req(), 0, z);
            n++;
         end
         req_if.valid <= 1'b0;
         repeat ($urandom_range(0, 30)) @(posedge clock);
      end
      req_if.valid <= 1'b0;
      stim_done = 1'b1;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // reset held at start, then the clearing pass runs inside the block
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end
endmodule

@@ files.f @@
hw/rtl/sabc_pkg.sv
hw/rtl/sabc_req_if.sv
hw/rtl/sabc_rsp_if.sv
hw/rtl/sabc_ram.sv
hw/rtl/set_assoc_block_buffer_cache_core.sv
hw/rtl/sabc_checker.sv
tb/tb_set_assoc_block_buffer_cache_core.sv
